// ----- rtl/rua_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rua_pkg
// Shared types and constants for the rectangle union area sweep unit.
// ----------------------------------------------------------------------------
package rua_pkg;

    localparam int X_W    = 15;
    localparam int Y_W    = 16;
    localparam int CNT_W  = 16;
    localparam int AREA_W = 31;
    localparam int LEN_W  = 16;

    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_INC  = CNT_W'(1);
    localparam logic [CNT_W-1:0]  CNT_DEC  = {CNT_W{1'b1}};

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic clr_write;
        logic load_in;
        logic mul;
        logic add_area;
        logic push_root;
        logic descend;
        logic ret_right;
        logic pop;
        logic cnt_capture;
        logic cnt_apply;
        logic fix_const;
        logic span_l_read;
        logic span_r_read;
        logic span_sum;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic clear_done;
        logic in_order_err;
        logic nonempty;
        logic outside;
        logic full_cover;
        logic sp_zero;
        logic parent_right_done;
        logic cnt_nonzero;
        logic is_leaf;
        logic out_busy;
    } dp_status_t;

endpackage

// ----- rtl/rua_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rua_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rua_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/rua_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rua_datapath
// Tree stores, node stack, area accumulator and result register.
// ----------------------------------------------------------------------------
module rua_datapath #(
    parameter int Y_CELLS = 32768
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rua_pkg::dp_cmd_t           cmd,
    output rua_pkg::dp_status_t        status,
    input  logic                       s_operation,
    input  logic [rua_pkg::X_W-1:0]    s_edge_x,
    input  logic [rua_pkg::Y_W-1:0]    s_y_low,
    input  logic [rua_pkg::Y_W-1:0]    s_y_high,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rua_pkg::AREA_W-1:0] m_total_area,
    output logic [rua_pkg::LEN_W-1:0]  m_covered_length,
    output logic                       m_order_error
);

    localparam int YW    = $clog2(Y_CELLS);
    localparam int SW    = YW + 1;
    localparam int SLOTS = 4 * Y_CELLS;
    localparam int NW    = $clog2(SLOTS);
    localparam int PD    = YW + 1;
    localparam int PIW   = $clog2(PD);
    localparam int PW    = SW + rua_pkg::X_W;
    localparam int AREA_W_L = rua_pkg::AREA_W;

    // Input request latches.
    logic                    op_reg;
    logic [rua_pkg::X_W-1:0] x_reg;
    logic [rua_pkg::X_W-1:0] prev_reg, prev_next;
    logic                    err_reg;
    logic                    nonempty_reg;
    logic [YW-1:0]           ql_reg, qr_reg;

    logic [AREA_W_L-1:0]     area_reg, area_next;
    logic [PW-1:0]           prod_reg;
    logic [SW-1:0]           root_reg, root_next;

    // Top frame and parent stack.
    logic [NW-1:0]  top_node_reg;
    logic [YW-1:0]  top_lo_reg, top_hi_reg;
    logic [NW-1:0]  par_node_reg [PD];
    logic [YW-1:0]  par_lo_reg   [PD];
    logic [YW-1:0]  par_hi_reg   [PD];
    logic           par_rd_reg   [PD];
    logic [PIW-1:0] sp_reg, sp_next;

    logic [rua_pkg::CNT_W-1:0] cnt_reg;
    logic [SW-1:0]             a_reg;
    logic [NW-1:0]             clr_addr_reg, clr_addr_next;
    logic                      m_valid_reg, m_valid_next;
    logic [rua_pkg::AREA_W-1:0] m_area_reg;
    logic [rua_pkg::LEN_W-1:0]  m_len_reg;
    logic                       m_err_reg;

    // Input decode.
    logic [16:0]   yhi_ext, yhi_clip, ylo_ext, qr_full;
    logic          in_nonempty;
    always_comb begin
        yhi_ext     = {1'b0, s_y_high};
        ylo_ext     = {1'b0, s_y_low};
        yhi_clip    = (yhi_ext > 17'(Y_CELLS)) ? 17'(Y_CELLS) : yhi_ext;
        in_nonempty = ylo_ext < yhi_clip;
        qr_full     = yhi_clip - 17'd1;
    end

    // Parent frame at the stack top and its midpoint.
    logic [PIW-1:0] pidx;
    logic [YW-1:0]  p_lo, p_hi, p_mid, t_mid;
    logic [NW-1:0]  p_node;
    always_comb begin
        pidx   = sp_reg - PIW'(1);
        p_lo   = par_lo_reg[pidx];
        p_hi   = par_hi_reg[pidx];
        p_node = par_node_reg[pidx];
        p_mid  = p_lo + ((p_hi - p_lo) >> 1);
        t_mid  = top_lo_reg + ((top_hi_reg - top_lo_reg) >> 1);
    end

    // Memories.
    logic [rua_pkg::CNT_W-1:0] cnt_rd, cnt_wdata, cnt_sum;
    logic                      cnt_we;
    logic [NW-1:0]             cnt_waddr;
    logic [SW-1:0]             span_rd, span_wdata, span_const;
    logic                      span_we;
    logic [NW-1:0]             span_waddr, span_raddr;

    always_comb begin
        cnt_sum    = cnt_rd + (op_reg ? rua_pkg::CNT_DEC : rua_pkg::CNT_INC);
        cnt_we     = cmd.clr_write | (cmd.cnt_capture & cmd.cnt_apply);
        cnt_waddr  = cmd.clr_write ? clr_addr_reg : top_node_reg;
        cnt_wdata  = cmd.clr_write ? '0 : cnt_sum;
        span_const = (cnt_reg != '0) ? (SW'(top_hi_reg - top_lo_reg) + SW'(1)) : '0;
        span_we    = cmd.clr_write | cmd.fix_const | cmd.span_sum;
        span_waddr = cmd.clr_write ? clr_addr_reg : top_node_reg;
        if (cmd.clr_write) begin
            span_wdata = '0;
        end else if (cmd.fix_const) begin
            span_wdata = span_const;
        end else begin
            span_wdata = a_reg + span_rd;
        end
        span_raddr = {top_node_reg[NW-2:0], cmd.span_r_read};
    end

    rua_ram #(.WIDTH(rua_pkg::CNT_W), .DEPTH(SLOTS)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (top_node_reg),
        .rdata (cnt_rd)
    );

    rua_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_span_ram (
        .aclk  (aclk),
        .we    (span_we),
        .waddr (span_waddr),
        .wdata (span_wdata),
        .raddr (span_raddr),
        .rdata (span_rd)
    );

    // Area accumulation and root length.
    logic [47:0] area_sum48;
    logic [31:0] root_ext;
    logic [rua_pkg::LEN_W-1:0] len_sat;
    always_comb begin
        area_sum48 = 48'(area_reg) + 48'(prod_reg);
        area_next  = area_reg;
        prev_next  = prev_reg;
        if (cmd.add_area) begin
            area_next = (area_sum48 > 48'(rua_pkg::AREA_MAX)) ? rua_pkg::AREA_MAX
                                                               : area_sum48[AREA_W_L-1:0];
            prev_next = x_reg;
        end
        root_next = root_reg;
        if (span_we && !cmd.clr_write && top_node_reg == NW'(1)) begin
            root_next = span_wdata;
        end
        root_ext = 32'(root_reg);
        len_sat  = (root_ext > 32'hFFFF) ? {rua_pkg::LEN_W{1'b1}}
                                         : root_ext[rua_pkg::LEN_W-1:0];
    end

    always_comb begin
        sp_next = sp_reg;
        if (cmd.push_root) begin
            sp_next = '0;
        end else if (cmd.descend) begin
            sp_next = sp_reg + PIW'(1);
        end else if (cmd.pop) begin
            sp_next = sp_reg - PIW'(1);
        end
        clr_addr_next = cmd.clr_write ? clr_addr_reg + NW'(1) : clr_addr_reg;
        m_valid_next  = cmd.out_load | (m_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg     <= '0;
            area_reg     <= '0;
            root_reg     <= '0;
            sp_reg       <= '0;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            prev_reg     <= prev_next;
            area_reg     <= area_next;
            root_reg     <= root_next;
            sp_reg       <= sp_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg       <= s_operation;
            x_reg        <= s_edge_x;
            err_reg      <= s_edge_x < prev_reg;
            nonempty_reg <= in_nonempty;
            ql_reg       <= s_y_low[YW-1:0];
            qr_reg       <= qr_full[YW-1:0];
        end
        if (cmd.mul) begin
            prod_reg <= PW'(root_reg) * PW'(x_reg - prev_reg);
        end
        if (cmd.push_root) begin
            top_node_reg <= NW'(1);
            top_lo_reg   <= '0;
            top_hi_reg   <= YW'(Y_CELLS - 1);
        end else if (cmd.descend) begin
            par_node_reg[sp_reg] <= top_node_reg;
            par_lo_reg[sp_reg]   <= top_lo_reg;
            par_hi_reg[sp_reg]   <= top_hi_reg;
            par_rd_reg[sp_reg]   <= 1'b0;
            top_node_reg         <= {top_node_reg[NW-2:0], 1'b0};
            top_hi_reg           <= t_mid;
        end else if (cmd.ret_right) begin
            par_rd_reg[pidx] <= 1'b1;
            top_node_reg     <= {p_node[NW-2:0], 1'b1};
            top_lo_reg       <= p_mid + YW'(1);
            top_hi_reg       <= p_hi;
        end else if (cmd.pop) begin
            top_node_reg <= p_node;
            top_lo_reg   <= p_lo;
            top_hi_reg   <= p_hi;
        end
        if (cmd.cnt_capture) begin
            cnt_reg <= cmd.cnt_apply ? cnt_sum : cnt_rd;
        end
        if (cmd.span_r_read) begin
            a_reg <= span_rd;
        end
        if (cmd.out_load) begin
            m_area_reg <= area_reg;
            m_len_reg  <= len_sat;
            m_err_reg  <= err_reg;
        end
    end

    always_comb begin
        status.clear_done        = clr_addr_reg == NW'(SLOTS - 1);
        status.in_order_err      = s_edge_x < prev_reg;
        status.nonempty          = nonempty_reg;
        status.outside           = (top_hi_reg < ql_reg) || (qr_reg < top_lo_reg);
        status.full_cover        = (ql_reg <= top_lo_reg) && (top_hi_reg <= qr_reg);
        status.sp_zero           = sp_reg == '0;
        status.parent_right_done = par_rd_reg[pidx];
        status.cnt_nonzero       = cnt_reg != '0;
        status.is_leaf           = top_lo_reg == top_hi_reg;
        status.out_busy          = m_valid_reg & ~m_ready;
    end

    assign m_valid          = m_valid_reg;
    assign m_total_area     = m_area_reg;
    assign m_covered_length = m_len_reg;
    assign m_order_error    = m_err_reg;

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("result not presented after load");
    a_root_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(root_reg) <= 32'(Y_CELLS))
        else $error("covered length exceeds the y range");
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.cnt_capture && cmd.cnt_apply) |-> status.full_cover)
        else $error("count changed on a node not inside the query");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !status.out_busy)
        else $error("pending result overwritten");

endmodule

// ----- rtl/rua_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rua_ctrl
// Sequencer: clearing pass, area update and segment tree walk.
// ----------------------------------------------------------------------------
module rua_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rua_pkg::dp_status_t status,
    output rua_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_VISIT,
        ST_CREQ,
        ST_CGOT,
        ST_FIX,
        ST_RREQ,
        ST_SUM,
        ST_RET,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   full_reg, full_next;

    always_comb begin
        state_next = state_reg;
        full_next  = full_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = status.in_order_err ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add_area = 1'b1;
                if (status.nonempty) begin
                    cmd.push_root = 1'b1;
                    state_next    = ST_VISIT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_VISIT: begin
                if (status.outside) begin
                    state_next = ST_RET;
                end else if (status.full_cover) begin
                    full_next  = 1'b1;
                    state_next = ST_CREQ;
                end else begin
                    cmd.descend = 1'b1;
                end
            end
            ST_CREQ: begin
                state_next = ST_CGOT;
            end
            ST_CGOT: begin
                cmd.cnt_capture = 1'b1;
                cmd.cnt_apply   = full_reg;
                state_next      = ST_FIX;
            end
            ST_FIX: begin
                if (status.cnt_nonzero || status.is_leaf) begin
                    cmd.fix_const = 1'b1;
                    state_next    = ST_RET;
                end else begin
                    cmd.span_l_read = 1'b1;
                    state_next      = ST_RREQ;
                end
            end
            ST_RREQ: begin
                cmd.span_r_read = 1'b1;
                state_next      = ST_SUM;
            end
            ST_SUM: begin
                cmd.span_sum = 1'b1;
                state_next   = ST_RET;
            end
            ST_RET: begin
                if (status.sp_zero) begin
                    state_next = ST_DONE;
                end else if (!status.parent_right_done) begin
                    cmd.ret_right = 1'b1;
                    state_next    = ST_VISIT;
                end else begin
                    // Both children are finished, so the parent is refreshed next.
                    cmd.pop    = 1'b1;
                    full_next  = 1'b0;
                    state_next = ST_CREQ;
                end
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            full_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            full_reg  <= full_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;

endmodule

// ----- rtl/rectangle_union_area_sweep_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_union_area_sweep_unit
// Sweep-line union area of rectangles over a coverage-count segment tree.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one edge request (operation, edge_x, y_low, y_high)
//   per handshake; requests must arrive in nondecreasing edge_x order. The
//   m_ channel returns one result per request: running area, covered length
//   and an order error flag for a request whose x went backwards.
//   A rejected request goes from acceptance straight to the output stage,
//   and an empty range first passes the multiply and area-add steps. A tree
//   update then visits each node it reaches in turn, fewest for a range that
//   is a single node near the root and most for a range with ragged
//   ends in a full-height tree. The walk is bounded by the single read port
//   of each tree store, one node access at a time.
//   One request is in work at a time; the next is taken once the current
//   result is in the output register, even while that result waits.
//   After reset both tree stores are cleared, one node per cycle;
//   s_ready stays low during that pass.
//   When the receiver stalls, the result stays on the m_ ports unchanged and
//   the block stops before loading the following result.
// ----------------------------------------------------------------------------
module rectangle_union_area_sweep_unit #(
    parameter int Y_CELLS = 32768
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_operation,
    input  logic [rua_pkg::X_W-1:0]    s_edge_x,
    input  logic [rua_pkg::Y_W-1:0]    s_y_low,
    input  logic [rua_pkg::Y_W-1:0]    s_y_high,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rua_pkg::AREA_W-1:0] m_total_area,
    output logic [rua_pkg::LEN_W-1:0]  m_covered_length,
    output logic                       m_order_error
);

    rua_pkg::dp_cmd_t    cmd;
    rua_pkg::dp_status_t status;

    rua_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rua_datapath #(.Y_CELLS(Y_CELLS)) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_operation      (s_operation),
        .s_edge_x         (s_edge_x),
        .s_y_low          (s_y_low),
        .s_y_high         (s_y_high),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_total_area     (m_total_area),
        .m_covered_length (m_covered_length),
        .m_order_error    (m_order_error)
    );

endmodule

// ----- bench/tb_rectangle_union_area_sweep_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rectangle_union_area_sweep_unit
// Drives edge requests into the sweep unit and checks every result against a
// coverage-count segment tree kept in the bench, with random idling on both
// channels, a pause until the result channel drains, and a no-progress watchdog.
// ----------------------------------------------------------------------------
module tb_rectangle_union_area_sweep_unit;

    localparam int CELLS     = 32768;
    localparam int NODES     = 4 * CELLS;
    localparam int WDOG_MAX  = 1000000;
    localparam int N_RANDOM  = 680;

    typedef struct {
        logic                      op;
        logic [rua_pkg::X_W-1:0]   x;
        logic [rua_pkg::Y_W-1:0]   ylo;
        logic [rua_pkg::Y_W-1:0]   yhi;
        bit                        hold;
    } edge_req_t;

    typedef struct {
        logic [rua_pkg::AREA_W-1:0] area;
        logic [rua_pkg::LEN_W-1:0]  len;
        logic                       err;
    } sweep_result_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic                         s_operation;
    logic [rua_pkg::X_W-1:0]      s_edge_x;
    logic [rua_pkg::Y_W-1:0]      s_y_low;
    logic [rua_pkg::Y_W-1:0]      s_y_high;
    logic                         m_valid;
    logic                         m_ready;
    logic [rua_pkg::AREA_W-1:0]   m_total_area;
    logic [rua_pkg::LEN_W-1:0]    m_covered_length;
    logic                         m_order_error;

    edge_req_t     pending_reqs[$];
    sweep_result_t expected_results[$];
    int            mismatch_count;
    int            sent_count;
    int            idle_cycles;
    bit            req_taken;

    // Bench copy of the tree and the sweep state.
    logic [rua_pkg::CNT_W-1:0]  node_count[NODES];
    int unsigned                node_span[NODES];
    logic [rua_pkg::AREA_W-1:0] area_acc;
    logic [rua_pkg::X_W-1:0]    last_x;

    rectangle_union_area_sweep_unit #(.Y_CELLS(CELLS)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_edge_x(s_edge_x), .s_y_low(s_y_low), .s_y_high(s_y_high),
        .m_valid(m_valid), .m_ready(m_ready), .m_total_area(m_total_area),
        .m_covered_length(m_covered_length), .m_order_error(m_order_error)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic logic [rua_pkg::LEN_W-1:0] root_len();
        return (node_span[1] > 32'hFFFF) ? 16'hFFFF : node_span[1][rua_pkg::LEN_W-1:0];
    endfunction

    function automatic void refresh_span(input int n, input int lo, input int hi);
        int unsigned a;
        int unsigned b;
        a = (2 * n < NODES) ? node_span[2 * n] : 0;
        b = (2 * n + 1 < NODES) ? node_span[2 * n + 1] : 0;
        if (node_count[n] != '0) begin
            node_span[n] = hi - lo + 1;
        end else if (lo == hi) begin
            node_span[n] = 0;
        end else begin
            node_span[n] = a + b;
        end
    endfunction

    // Walks the tree with an explicit stack: stage 0 visits a node, stage 1
    // descends right after the left subtree, stage 2 recomputes on the way up.
    function automatic void apply_range(input logic [rua_pkg::CNT_W-1:0] delta,
                                        input int ql, input int qr);
        int st_node[40];
        int st_lo[40];
        int st_hi[40];
        int st_stage[40];
        int sp;
        int n;
        int lo;
        int hi;
        int mid;
        sp = 0;
        st_node[0] = 1; st_lo[0] = 0; st_hi[0] = CELLS - 1; st_stage[0] = 0;
        sp = 1;
        while (sp > 0) begin
            n = st_node[sp-1]; lo = st_lo[sp-1]; hi = st_hi[sp-1];
            mid = lo + (hi - lo) / 2;
            case (st_stage[sp-1])
                0: begin
                    if (n >= NODES || hi < ql || qr < lo) begin
                        sp--;
                    end else if (ql <= lo && hi <= qr) begin
                        node_count[n] = node_count[n] + delta;
                        refresh_span(n, lo, hi);
                        sp--;
                    end else begin
                        st_stage[sp-1] = 1;
                        st_node[sp] = 2 * n; st_lo[sp] = lo; st_hi[sp] = mid;
                        st_stage[sp] = 0;
                        sp++;
                    end
                end
                1: begin
                    st_stage[sp-1] = 2;
                    st_node[sp] = 2 * n + 1; st_lo[sp] = mid + 1; st_hi[sp] = hi;
                    st_stage[sp] = 0;
                    sp++;
                end
                default: begin
                    refresh_span(n, lo, hi);
                    sp--;
                end
            endcase
        end
    endfunction

    function automatic sweep_result_t predict_sweep(input logic op,
            input logic [rua_pkg::X_W-1:0] x, input logic [rua_pkg::Y_W-1:0] ylo,
            input logic [rua_pkg::Y_W-1:0] yhi);
        sweep_result_t r;
        longint unsigned sum;
        int top;
        if (x < last_x) begin
            r.area = area_acc; r.len = root_len(); r.err = 1'b1;
            return r;
        end
        sum = longint'(area_acc) + longint'(node_span[1]) * longint'(x - last_x);
        area_acc = (sum > longint'(rua_pkg::AREA_MAX)) ? rua_pkg::AREA_MAX
                                                       : sum[rua_pkg::AREA_W-1:0];
        top = (int'(yhi) > CELLS) ? CELLS : int'(yhi);
        if (int'(ylo) < top)
            apply_range(op ? rua_pkg::CNT_DEC : rua_pkg::CNT_INC, int'(ylo), top - 1);
        last_x = x;
        r.area = area_acc; r.len = root_len(); r.err = 1'b0;
        return r;
    endfunction

    task automatic add_req(input int op, input int x, input int ylo, input int yhi,
                           input bit hold = 1'b0);
        edge_req_t q;
        q.op = op[0]; q.x = x[rua_pkg::X_W-1:0];
        q.ylo = ylo[rua_pkg::Y_W-1:0]; q.yhi = yhi[rua_pkg::Y_W-1:0];
        q.hold = hold;
        pending_reqs = {pending_reqs, q};
    endtask

    // Driver: the request sits on the s_ ports until a rising edge takes it.
    always @(negedge aclk) begin
        bit idle;
        int pct;
        pct = (sent_count < 233) ? 12 : (sent_count < 466) ? 49 : 0;
        idle = ($urandom_range(0, 99) < pct);
        if (!aresetn || (s_valid && !req_taken)) begin
            // hold the current request
        end else if (pending_reqs.size() > 0 && !idle &&
                     !(pending_reqs[0].hold && expected_results.size() > 0)) begin
            s_operation <= pending_reqs[0].op;
            s_edge_x    <= pending_reqs[0].x;
            s_y_low     <= pending_reqs[0].ylo;
            s_y_high    <= pending_reqs[0].yhi;
            s_valid     <= 1'b1;
            void'(pending_reqs.pop_front());
        end else begin
            s_valid <= 1'b0;
        end
        pct = (sent_count < 233) ? 49 : (sent_count < 466) ? 12 : 0;
        m_ready <= ($urandom_range(0, 99) >= pct);
    end

    // Monitor, predictor and watchdog.
    always @(posedge aclk) begin
        sweep_result_t e;
        req_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                req_taken = 1'b1;
                sent_count++;
                expected_results = {expected_results,
                    predict_sweep(s_operation, s_edge_x, s_y_low, s_y_high)};
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    e = expected_results.pop_front();
                    if (m_total_area !== e.area)
                        report_mismatch($sformatf("total_area %0d, want %0d",
                                                  m_total_area, e.area));
                    if (m_covered_length !== e.len)
                        report_mismatch($sformatf("covered_length %0d, want %0d",
                                                  m_covered_length, e.len));
                    if (m_order_error !== e.err)
                        report_mismatch($sformatf("order_error %0b, want %0b",
                                                  m_order_error, e.err));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_MAX) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int x_cur;
        int r;
        int k;
        int lo;
        int hi;
        int open_lo[$];
        int open_hi[$];
        aresetn = 1'b0; s_valid = 1'b0; m_ready = 1'b0; s_operation = 1'b0;
        s_edge_x = '0; s_y_low = '0; s_y_high = '0;
        mismatch_count = 0; sent_count = 0; idle_cycles = 0; req_taken = 1'b0;
        area_acc = '0; last_x = '0;
        for (int i = 0; i < NODES; i++) begin
            node_count[i] = '0; node_span[i] = 0;
        end

        // Directed requests: full height, edges of the y range, clipping,
        // empty ranges, a close with no open, and an out-of-order edge.
        add_req(0, 0, 0, 32768);
        add_req(1, 10, 0, 32768);
        add_req(0, 10, 0, 1);
        add_req(0, 12, 32767, 32768);
        add_req(0, 15, 100, 65535);
        add_req(0, 18, 50, 50);
        add_req(1, 18, 65535, 0);
        add_req(1, 20, 5, 9, 1'b1);
        add_req(0, 5, 0, 32768);
        add_req(1, 25, 100, 65535);
        add_req(0, 25, 0, 3);
        add_req(1, 27, 0, 1);
        add_req(1, 30, 32767, 32768);
        x_cur = 30;

        for (int i = 0; i < N_RANDOM; i++) begin
            r = $urandom_range(0, 99);
            x_cur = x_cur + $urandom_range(0, 90);
            if (x_cur > 32767) x_cur = 32767;
            if (r < 4 && x_cur > 0) begin
                add_req($urandom_range(0, 1), x_cur - $urandom_range(1, x_cur),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
            end else if (r < 10) begin
                add_req($urandom_range(0, 1), x_cur, $urandom_range(0, 65535),
                        $urandom_range(0, 65535), i == 300);
            end else if (r < 50 && open_lo.size() > 0) begin
                k = $urandom_range(0, open_lo.size() - 1);
                add_req(1, x_cur, open_lo[k], open_hi[k], i == 300);
                open_lo.delete(k); open_hi.delete(k);
            end else begin
                lo = $urandom_range(0, 32767);
                hi = lo + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 32768)
                                                     : $urandom_range(1, 64));
                add_req(0, x_cur, lo, hi, i == 300);
                open_lo = {open_lo, lo}; open_hi = {open_hi, hi};
            end
        end
        add_req(0, 32767, 0, 32768);
        add_req(1, 0, 0, 32768);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        wait (pending_reqs.size() == 0 && !s_valid && expected_results.size() == 0);
        repeat (300) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
